FILE: sv/assert_macros.svh
// Assertion macros for the codec top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on rising clk outside reset.
`define GCR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on rising clk outside reset.
`define GCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/gcr_pkg.sv
// Shared types, code table and table lookups for the group code codec.
package gcr_pkg;

	localparam int unsigned MaxPendCnt = 9;

	localparam logic [4:0] NibToCode [16] = '{
		5'h0A, 5'h0B, 5'h12, 5'h13, 5'h0E, 5'h0F, 5'h16, 5'h17,
		5'h09, 5'h19, 5'h1A, 5'h1B, 5'h0D, 5'h1D, 5'h1E, 5'h15
	};

	typedef struct packed {
		logic [7:0] out_byte;
		logic       code_error;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] n_res;
		result_t    res0;
		result_t    res1;
		logic [8:0] pend_bits;
		logic [3:0] pend_cnt;
	} step_t;

	// Returns the nibble in the low four bits; bit 4 flags a code with no entry.
	function automatic logic [4:0] code_to_nib(input logic [4:0] code);
		logic [4:0] res;
		res = 5'h10;
		for (int i = 0; i < 16; i++) begin
			if (res[4] && NibToCode[i] == code) begin
				res = {1'b0, 4'(i)};
			end
		end
		return res;
	endfunction

endpackage

FILE: sv/gcr_byte_stream_codec.sv
// Top level of the 4-to-5 group code byte-stream codec.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+----------------------------------------
//  in      | to block  | in_valid/in_stall   | data_in, first_of_buffer
//  out     | from block| out_valid/out_stall | out_byte, code_error, last_of_run
//  cfg     | to block  | cfg_valid/cfg_ready | direction
//
//  A word is taken into the input register, where its results are computed in a
//  single pass and loaded into a two-slot output buffer once they fit there.
//  Throughput is one input word per cycle when it yields at most one result and
//  out_stall stays low; after an encode word yielding two results the next word
//  waits until the buffer can take it, as the output buffer's single read port
//  passes one result out at a time.
//  Reset (arst_n low) clears direction to decode and empties the residual queue,
//  input register and output buffer.
//  out_stall holds the buffer head; a full buffer holds the input register, which
//  raises in_stall. cfg_ready is high only while the block holds no word.
`include "assert_macros.svh"

module gcr_byte_stream_codec (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_in,
	input  logic       first_of_buffer,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       code_error,
	output logic       last_of_run,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       direction
);

	// input register stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;

	// architectural state
	logic       direction_q;
	logic [8:0] pend_bits_q;
	logic [3:0] pend_cnt_q;

	gcr_pkg::step_t   step;
	gcr_pkg::result_t head;
	logic             space;
	logic [1:0]       fill;
	logic             commit;
	logic             in_take;
	logic             cfg_take;

	// commit the staged word when its results fit; a word with none always commits
	assign commit   = valid_s1 && (step.n_res == 2'd0 || space);
	assign in_stall = valid_s1 && !commit;
	assign in_take  = in_valid && !in_stall;
	assign cfg_ready = !valid_s1 && (fill == 2'd0);
	assign cfg_take  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1  <= data_in;
			first_s1 <= first_of_buffer;
		end
	end

	// direction write also drops the residual queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			pend_bits_q <= 9'd0;
			pend_cnt_q  <= 4'd0;
		end else if (cfg_take) begin
			direction_q <= direction;
			pend_bits_q <= 9'd0;
			pend_cnt_q  <= 4'd0;
		end else if (commit) begin
			pend_bits_q <= step.pend_bits;
			pend_cnt_q  <= step.pend_cnt;
		end
	end

	gcr_step u_step (
		.direction      (direction_q),
		.data_in        (data_s1),
		.first_of_buffer(first_s1),
		.pend_bits      (pend_bits_q),
		.pend_cnt       (pend_cnt_q),
		.step           (step)
	);

	gcr_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (commit && step.n_res != 2'd0),
		.load_n   (step.n_res),
		.load_r0  (step.res0),
		.load_r1  (step.res1),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.head     (head),
		.space    (space),
		.fill     (fill)
	);

	assign out_byte    = head.out_byte;
	assign code_error  = head.code_error;
	assign last_of_run = head.last_of_run;

	`GCR_ASSERT_NOW(a_enc_yields, commit && direction_q, step.n_res != 2'd0, "encode word yielded no result")
	`GCR_ASSERT_NOW(a_pend_range, 1'b1, pend_cnt_q <= 4'(gcr_pkg::MaxPendCnt), "residual count beyond nine bits")
	`GCR_ASSERT_NEXT(a_cfg_clears, cfg_take, pend_cnt_q == 4'd0, "direction write left residual bits")
	`GCR_ASSERT_NOW(a_fill_range, 1'b1, fill != 2'd3, "output buffer over two words")

endmodule

FILE: sv/gcr_step.sv
// Single-pass encode/decode of one word against the residual bit queue.
module gcr_step (
	input  logic           direction,
	input  logic [7:0]     data_in,
	input  logic           first_of_buffer,
	input  logic [8:0]     pend_bits,
	input  logic [3:0]     pend_cnt,
	output gcr_pkg::step_t step
);

	logic [8:0]  pb;
	logic [3:0]  pc;
	logic [4:0]  cnt;
	logic [4:0]  rem;
	logic [18:0] acc;
	logic [18:0] mask;
	logic [9:0]  grp;
	logic [4:0]  hi;
	logic [4:0]  lo;

	always_comb begin
		// drop residual bits at a new buffer, then clamp the count
		pb = first_of_buffer ? 9'd0 : pend_bits;
		pc = first_of_buffer ? 4'd0 : pend_cnt;
		if (pc > 4'(gcr_pkg::MaxPendCnt)) begin
			pc = 4'(gcr_pkg::MaxPendCnt);
		end

		step      = '0;
		acc       = '0;
		cnt       = '0;
		rem       = '0;
		grp       = '0;
		hi        = '0;
		lo        = '0;

		if (direction) begin
			grp = {gcr_pkg::NibToCode[data_in[7:4]], gcr_pkg::NibToCode[data_in[3:0]]};
			acc = {pb, grp};
			cnt = {1'b0, pc} + 5'd10;
			step.res0.out_byte = 8'(acc >> (cnt - 5'd8));
			if (cnt >= 5'd16) begin
				step.n_res = 2'd2;
				step.res1.out_byte = 8'(acc >> (cnt - 5'd16));
				step.res1.last_of_run = 1'b1;
				rem = cnt - 5'd16;
			end else begin
				step.n_res = 2'd1;
				step.res0.last_of_run = 1'b1;
				rem = cnt - 5'd8;
			end
		end else begin
			acc = {2'b00, pb, data_in};
			cnt = {1'b0, pc} + 5'd8;
			if (cnt >= 5'd10) begin
				grp = 10'(acc >> (cnt - 5'd10));
				hi  = gcr_pkg::code_to_nib(grp[9:5]);
				lo  = gcr_pkg::code_to_nib(grp[4:0]);
				step.n_res = 2'd1;
				step.res0.last_of_run = 1'b1;
				if (lo[4]) begin
					step.res0.out_byte   = 8'hFF;
					step.res0.code_error = 1'b1;
				end else if (hi[4]) begin
					step.res0.out_byte   = {4'hF, lo[3:0]};
					step.res0.code_error = 1'b1;
				end else begin
					step.res0.out_byte = {hi[3:0], lo[3:0]};
				end
				rem = cnt - 5'd10;
			end else begin
				rem = cnt;
			end
		end

		mask           = (19'd1 << rem) - 19'd1;
		step.pend_bits = 9'(acc & mask);
		step.pend_cnt  = 4'(rem);
	end

endmodule

FILE: sv/gcr_out_buf.sv
// Two-slot result buffer feeding the output channel one word per cycle while out_stall is low.
module gcr_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [1:0]       load_n,
	input  gcr_pkg::result_t load_r0,
	input  gcr_pkg::result_t load_r1,
	input  logic             out_stall,
	output logic             out_valid,
	output gcr_pkg::result_t head,
	output logic             space,
	output logic [1:0]       fill
);

	gcr_pkg::result_t r0_q;
	gcr_pkg::result_t r1_q;
	logic [1:0]       cnt_q;
	logic             take;

	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && !out_stall;
	// buffer is free at this edge when it is empty or its last word leaves now
	assign space     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);
	assign head      = r0_q;
	assign fill      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_n;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= load_r0;
			r1_q <= load_r1;
		end else if (take) begin
			r0_q <= r1_q;
		end
	end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the group code byte-stream codec.
`timescale 1ns / 1ps

module tb;

	// direction register values
	localparam bit DirDecode = 1'b0;
	localparam bit DirEncode = 1'b1;

	localparam int PhaseCount = 8;
	localparam int PhaseWords = 153;
	localparam int DrainHold = 8;     // cycles to hold after the last result word
	localparam int QuietLimit = 1000; // cycles without any handshake before giving up

	// 4-bit nibble to 5-bit disk group code
	localparam logic [4:0] GroupCode [16] = '{
		5'h0A, 5'h0B, 5'h12, 5'h13, 5'h0E, 5'h0F, 5'h16, 5'h17,
		5'h09, 5'h19, 5'h1A, 5'h1B, 5'h0D, 5'h1D, 5'h1E, 5'h15
	};

	// One directed word: mode, payload, and a hand-typed result where the value is
	// obvious (single result word, last_of_run set); other rows use the predictor.
	typedef struct packed {
		logic       dir;
		logic [7:0] data;
		logic       fob;
		logic       typed;
		logic [7:0] exp_byte;
		logic       exp_err;
	} stim_row_t;

	localparam int DirectedRows = 23;
	localparam stim_row_t DirectedTable [DirectedRows] = '{
		// decode: nibble 0 in both halves, bits 01010_01010
		'{DirDecode, 8'h52, 1'b1, 1'b0, 8'h00, 1'b0},
		'{DirDecode, 8'h80, 1'b0, 1'b1, 8'h00, 1'b0},
		// decode: all-zero group, both codes invalid
		'{DirDecode, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
		'{DirDecode, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1},
		// decode: all-one group, both codes invalid
		'{DirDecode, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
		'{DirDecode, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1},
		// decode: invalid high code only, high nibble forced to F
		'{DirDecode, 8'h02, 1'b1, 1'b0, 8'h00, 1'b0},
		'{DirDecode, 8'h80, 1'b0, 1'b1, 8'hF0, 1'b1},
		// decode: nibble F twice, a legal 0xFF
		'{DirDecode, 8'hAD, 1'b1, 1'b0, 8'h00, 1'b0},
		'{DirDecode, 8'h40, 1'b0, 1'b1, 8'hFF, 1'b0},
		// decode: residual bits carried across words
		'{DirDecode, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0},
		'{DirDecode, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0},
		'{DirDecode, 8'h3C, 1'b0, 1'b0, 8'h00, 1'b0},
		'{DirDecode, 8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},
		// encode: extremes from a clean queue give one word each
		'{DirEncode, 8'h00, 1'b1, 1'b1, 8'h52, 1'b0},
		'{DirEncode, 8'hFF, 1'b1, 1'b1, 8'hAD, 1'b0},
		// encode: residual grows until a word yields two results
		'{DirEncode, 8'h0F, 1'b0, 1'b0, 8'h00, 1'b0},
		'{DirEncode, 8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{DirEncode, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0},
		'{DirEncode, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0},
		// encode: new buffer drops the partial byte
		'{DirEncode, 8'h37, 1'b1, 1'b0, 8'h00, 1'b0},
		// back to decode; the register write clears the residual queue
		'{DirDecode, 8'h52, 1'b0, 1'b0, 8'h00, 1'b0},
		'{DirDecode, 8'h80, 1'b0, 1'b1, 8'h00, 1'b0}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_in;
	logic       first_of_buffer;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       code_error;
	logic       last_of_run;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       direction;

	gcr_byte_stream_codec uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_in        (data_in),
		.first_of_buffer(first_of_buffer),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.code_error     (code_error),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.direction      (direction)
	);

	// predictor state: mirrors the block's register and residual bit queue
	logic       mode_q;
	logic [8:0] resid_bits;
	int         resid_cnt;

	// coded stream generator for well-formed decode traffic
	logic [15:0] gen_bits;
	int          gen_cnt;

	gcr_pkg::result_t expected_words [$];
	int      mismatches = 0;
	int      quiet_cycles = 0;
	int      send_pct;
	int      stall_pct;

	always #4 clk = ~clk;

	// Look up the nibble of a 5-bit code; bit 4 set means no entry.
	function automatic logic [4:0] group_nibble(input logic [4:0] code);
		logic [4:0] nib;
		nib = 5'h10;
		for (int i = 15; i >= 0; i--) begin
			if (GroupCode[i] == code) begin
				nib = {1'b0, 4'(i)};
			end
		end
		return nib;
	endfunction

	// Advance the predictor by one input word and return up to two result words.
	task automatic gcr_predict(input logic [7:0] d, input logic f, output int n,
			output gcr_pkg::result_t r0, output gcr_pkg::result_t r1);
		logic [18:0]      acc;
		logic [9:0]       grp;
		logic [4:0]       hi;
		logic [4:0]       lo;
		int               cnt;
		gcr_pkg::result_t w;
		n = 0;
		r0 = '0;
		r1 = '0;
		// drop the partial bits of the previous buffer
		if (f) begin
			resid_bits = '0;
			resid_cnt = 0;
		end
		if (mode_q == DirEncode) begin
			grp = {GroupCode[d[7:4]], GroupCode[d[3:0]]};
			acc = {resid_bits, grp};
			cnt = resid_cnt + 10;
			while (cnt >= 8 && n < 2) begin
				w.out_byte = 8'(acc >> (cnt - 8));
				w.code_error = 1'b0;
				w.last_of_run = 1'b0;
				if (n == 0) r0 = w;
				else r1 = w;
				cnt -= 8;
				n++;
			end
			if (n == 1) r0.last_of_run = 1'b1;
			else r1.last_of_run = 1'b1;
		end else begin
			acc = {2'b00, resid_bits, d};
			cnt = resid_cnt + 8;
			if (cnt >= 10) begin
				grp = 10'(acc >> (cnt - 10));
				hi = group_nibble(grp[9:5]);
				lo = group_nibble(grp[4:0]);
				r0.last_of_run = 1'b1;
				r0.code_error = hi[4] | lo[4];
				// a bad low code wins over a bad high code
				if (lo[4]) r0.out_byte = 8'hFF;
				else if (hi[4]) r0.out_byte = {4'hF, lo[3:0]};
				else r0.out_byte = {hi[3:0], lo[3:0]};
				cnt -= 10;
				n = 1;
			end
		end
		resid_bits = 9'(acc & ((19'd1 << cnt) - 19'd1));
		resid_cnt = cnt;
	endtask

	// Produce the next byte of a coded stream; one code in twenty is drawn from all 32 values.
	function automatic logic [7:0] next_coded_byte();
		logic [4:0] code;
		logic [7:0] b;
		while (gen_cnt < 8) begin
			if ($urandom_range(0, 19) == 0) code = 5'($urandom_range(0, 31));
			else code = GroupCode[$urandom_range(0, 15)];
			gen_bits = {gen_bits[10:0], code};
			gen_cnt += 5;
		end
		b = 8'(gen_bits >> (gen_cnt - 8));
		gen_cnt -= 8;
		return b;
	endfunction

	// Offer one word, hold it until taken, then queue what it should produce.
	task automatic send_word(input logic [7:0] d, input logic f, input logic typed,
			input gcr_pkg::result_t want);
		int               n;
		gcr_pkg::result_t r0;
		gcr_pkg::result_t r1;
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_in <= d;
		first_of_buffer <= f;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		gcr_predict(d, f, n, r0, r1);
		if (typed) begin
			expected_words.push_back(want);
		end else begin
			if (n > 0) expected_words.push_back(r0);
			if (n > 1) expected_words.push_back(r1);
		end
	endtask

	// Drop valid, wait out every expected word, then hold for the pipeline.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DrainHold) @(posedge clk);
	endtask

	// Write the direction register; the block clears its residual queue.
	task automatic write_direction(input logic v);
		cfg_valid <= 1'b1;
		direction <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		mode_q = v;
		resid_bits = '0;
		resid_cnt = 0;
		gen_bits = '0;
		gen_cnt = 0;
	endtask

	// Receiver side: stall at random at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
	end

	// Check every accepted result word against the oldest expectation and
	// watch for a hung handshake.
	always @(posedge clk) begin
		gcr_pkg::result_t exp_w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word byte=%02h err=%0b last=%0b", $time,
						out_byte, code_error, last_of_run);
					mismatches++;
				end else begin
					exp_w = expected_words.pop_front();
					if (out_byte !== exp_w.out_byte) begin
						$display("%0t: out_byte expected %02h actual %02h", $time,
							exp_w.out_byte, out_byte);
						mismatches++;
					end
					if (code_error !== exp_w.code_error) begin
						$display("%0t: code_error expected %0b actual %0b", $time,
							exp_w.code_error, code_error);
						mismatches++;
					end
					if (last_of_run !== exp_w.last_of_run) begin
						$display("%0t: last_of_run expected %0b actual %0b", $time,
							exp_w.last_of_run, last_of_run);
						mismatches++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QuietLimit) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0]       d;
		logic             f;
		logic             dir_sel;
		gcr_pkg::result_t want;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_in = '0;
		first_of_buffer = 1'b0;
		cfg_valid = 1'b0;
		direction = DirDecode;
		send_pct = 0;
		stall_pct = 0;
		mode_q = DirDecode;
		resid_bits = '0;
		resid_cnt = 0;
		gen_bits = '0;
		gen_cnt = 0;

		// hold reset once, then release it
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling; change direction only once the block is empty
		for (int i = 0; i < DirectedRows; i++) begin
			if (DirectedTable[i].dir != mode_q) begin
				drain_results();
				write_direction(DirectedTable[i].dir);
			end
			want.out_byte = DirectedTable[i].exp_byte;
			want.code_error = DirectedTable[i].exp_err;
			want.last_of_run = 1'b1;
			send_word(DirectedTable[i].data, DirectedTable[i].fob,
				DirectedTable[i].typed, want);
		end

		// random phases: cycle through the idling patterns and both directions,
		// rewriting the same value twice to see the queue clear on any write
		for (int p = 0; p < PhaseCount; p++) begin
			drain_results();
			case (p % 4)
				0: begin send_pct = 0;  stall_pct = 0;  end
				1: begin send_pct = 49; stall_pct = 0;  end
				2: begin send_pct = 0;  stall_pct = 49; end
				default: begin send_pct = 13; stall_pct = 13; end
			endcase
			dir_sel = (p == 0 || p == 3 || p == 4 || p == 6) ? DirEncode : DirDecode;
			write_direction(dir_sel);
			for (int k = 0; k < PhaseWords; k++) begin
				// pause mid-phase until every expected word is out
				if (k == PhaseWords / 2) drain_results();
				f = ($urandom_range(0, 11) == 0);
				if (f) begin
					gen_bits = '0;
					gen_cnt = 0;
				end
				if (mode_q == DirEncode) begin
					case ($urandom_range(0, 9))
						0: d = 8'h00;
						1: d = 8'hFF;
						default: d = 8'($urandom_range(0, 255));
					endcase
				end else if ($urandom_range(0, 4) != 0) begin
					d = next_coded_byte();
				end else begin
					// noise word: knocks the stream out of step until the next buffer
					d = 8'($urandom_range(0, 255));
				end
				send_word(d, f, 1'b0, '0);
			end
		end

		send_pct = 0;
		drain_results();
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
